// ===== rtl/vfd_pkg.sv =====
// Shared types, constants and helper functions for the VADPCM frame decoder.
// No dependencies; imported by vfd_mac, vadpcm_frame_decoder and tb_top.
`timescale 1ns / 1ps
`default_nettype none

package vfd_pkg;

   localparam int NUM_PREDICTORS_DEF = 16;
   localparam int COEFS_PER_PRED     = 16;
   localparam int HALF_LEN           = 8;
   localparam int REQ_DATA_W         = 32;
   localparam int RSP_DATA_W         = 24;

   localparam logic [3:0] RANGE_FOUR_BIT = 4'd12;
   localparam logic [3:0] RANGE_TWO_BIT  = 4'd14;
   localparam logic [4:0] LAST_POS       = 5'd15;
   localparam logic [7:0] HIST_OLDER     = 8'd0;
   localparam logic [7:0] HIST_NEWER     = 8'd1;

   typedef enum logic [1:0] {
      OP_COEF   = 2'd0,
      OP_HIST   = 2'd1,
      OP_HEADER = 2'd2,
      OP_DATA   = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_LOAD  = 5'b00010,
      S_ISSUE = 5'b00100,
      S_DRAIN = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      OPB_OLDER = 2'd0,
      OPB_NEWER = 2'd1,
      OPB_RESID = 2'd2
   } opb_type;

   typedef struct packed {
      logic               init;
      logic signed [15:0] resid;
      logic               valid;
   } mac_ctl_type;

   function automatic logic signed [15:0] unpack_residual(
      input logic [7:0] byte_v,
      input logic [1:0] k,
      input logic       two_bit,
      input logic [3:0] scale
   );
      logic [1:0]         crumb;
      logic signed [15:0] placed;
      logic [3:0]         rsh;
      if (two_bit) begin
         case (k)
            2'd0:    crumb = byte_v[7:6];
            2'd1:    crumb = byte_v[5:4];
            2'd2:    crumb = byte_v[3:2];
            default: crumb = byte_v[1:0];
         endcase
         placed = {crumb, 14'b0};
         rsh = (scale < RANGE_TWO_BIT) ? RANGE_TWO_BIT - scale : 4'd0;
      end else begin
         crumb = 2'b00;
         placed = k[0] ? {byte_v[3:0], 12'b0} : {byte_v[7:4], 12'b0};
         rsh = (scale < RANGE_FOUR_BIT) ? RANGE_FOUR_BIT - scale : 4'd0;
      end
      return placed >>> rsh;
   endfunction

   function automatic logic signed [15:0] sat16(input logic [31:0] acc);
      logic signed [20:0] t;
      t = $signed(acc[31:11]);
      if (t > 21'sd32767) begin
         return 16'sh7fff;
      end else if (t < -21'sd32768) begin
         return 16'sh8000;
      end
      return t[15:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/vfd_mac.sv =====
// Multiply-accumulate pipeline: one registered 16x16 product per cycle,
// summed into a wrapping 32-bit accumulator. Depends on vfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vfd_mac (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire vfd_pkg::mac_ctl_type ctl,
   input  wire logic signed [15:0]   coef,
   input  wire logic signed [15:0]   opb,
   output logic [31:0]               acc,
   output logic                      busy
);
   import vfd_pkg::*;

   logic signed [31:0] prod_ff, prod_in;
   logic               prod_valid_ff;
   logic [31:0]        acc_ff, acc_in;

   always_comb begin
      prod_in = coef * opb;
      acc_in = acc_ff;
      if (ctl.init) begin
         acc_in = {{5{ctl.resid[15]}}, ctl.resid, 11'b0};
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;
   assign busy = prod_valid_ff;

`ifndef NO_ASSERTIONS
   a_init_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.init |-> !prod_valid_ff && !ctl.valid)
      else $error("accumulator seeded while products in flight");
   a_prod_follows: assert property (@(posedge clock) disable iff (reset)
      ctl.valid |=> prod_valid_ff)
      else $error("product lost in pipeline");
   a_no_stray: assert property (@(posedge clock) disable iff (reset)
      !ctl.valid |=> !prod_valid_ff)
      else $error("product without operand");
`endif

endmodule

`default_nettype wire

// ===== rtl/vadpcm_frame_decoder.sv =====
// Top level of the VADPCM frame decoder: op decode, sequencer, coefficient
// and residual memories, output register. Depends on vfd_pkg and vfd_mac.
`timescale 1ns / 1ps
`default_nettype none

// Coefficient, history and header ops are taken while idle and leave the
// decoder idle. A data byte yields two samples (four-bit mode) or four
// (two-bit mode), fewer where the frame ends; sample number i of its
// half-frame (i = 0..7) needs i + 2 products, which go one per cycle through
// a single multiplier fed from the coefficient memory's one read port, after
// a seed step and before pipeline drain and saturate steps. A data byte
// after a finished frame is accepted and dropped. The next op is accepted
// once the last sample of a byte sits in the output register.

module vadpcm_frame_decoder #(
   parameter int NUM_PREDICTORS = vfd_pkg::NUM_PREDICTORS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // csr_wdata: two_bit_mode
   input  wire logic                            csr_we,
   input  wire logic                            csr_wdata,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // req_tdata: index[7:0], value[23:8], data_byte[31:24]
   input  wire logic [vfd_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: op[1:0]
   input  wire logic [1:0]                      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // rsp_tdata: sample[15:0], sample_index[19:16], zero[23:20]
   output logic [vfd_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                 rsp_tlast,
   // rsp_tuser: frame_done[0]
   output logic                                 rsp_tuser
);
   import vfd_pkg::*;

   localparam int COEF_DEPTH = NUM_PREDICTORS * COEFS_PER_PRED;
   localparam int COEF_AW    = $clog2(COEF_DEPTH);
   localparam int PRED_W     = (NUM_PREDICTORS > 1) ? $clog2(NUM_PREDICTORS) : 1;

   logic signed [15:0] coef_mem [COEF_DEPTH];
   logic signed [15:0] res_mem [HALF_LEN];

   state_type          state_ff, state_in;
   logic               two_bit_ff, two_bit_in;
   logic [4:0]         pos_ff, pos_in;
   logic [1:0]         kk_ff, kk_in;
   logic [7:0]         byte_ff, byte_in;
   logic               mode_ff, mode_in;
   logic [3:0]         scale_ff, scale_in;
   logic [PRED_W-1:0]  pred_ff, pred_in;
   logic signed [15:0] older_ff, older_in;
   logic signed [15:0] newer_ff, newer_in;
   logic signed [15:0] six_ff, six_in;
   logic [3:0]         term_ff, term_in;
   logic               rd_valid_ff, rd_valid_in;
   opb_type            sel_ff, sel_in;
   logic signed [15:0] coef_rd_ff;
   logic signed [15:0] res_rd_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_sample_ff, rsp_sample_in;
   logic [3:0]         rsp_idx_ff, rsp_idx_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_done_ff, rsp_done_in;

   op_type             op;
   logic [7:0]         idx;
   logic signed [15:0] val;
   logic [7:0]         dbyte;
   logic               accept;
   logic [2:0]         half_pos;
   logic [3:0]         last_term;
   logic signed [15:0] res_cur;
   logic signed [15:0] sample_cur;
   logic               sample_last;
   logic               out_free;
   logic               load_rsp;
   logic               coef_we;
   logic               res_we;
   logic               rd_en;
   logic [3:0]         coef_k;
   logic [COEF_AW-1:0] coef_raddr;
   logic [2:0]         res_raddr;
   logic [3:0]         pred_raw;
   logic signed [15:0] opb;
   mac_ctl_type        mac_ctl;
   logic [31:0]        mac_acc;
   logic               mac_busy;

   assign op = op_type'(req_tuser);
   assign idx = req_tdata[7:0];
   assign val = req_tdata[23:8];
   assign dbyte = req_tdata[31:24];
   assign req_tready = (state_ff == S_IDLE);
   assign accept = req_tvalid && req_tready;
   assign half_pos = pos_ff[2:0];
   assign last_term = {1'b0, half_pos} + 4'd1;
   assign res_cur = unpack_residual(byte_ff, kk_ff, mode_ff, scale_ff);
   assign sample_cur = sat16(mac_acc);
   assign sample_last = (kk_ff == (mode_ff ? 2'd3 : 2'd1)) || (pos_ff == LAST_POS);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign load_rsp = (state_ff == S_DONE) && out_free;
   assign coef_we = accept && (op == OP_COEF) && (9'(idx) < 9'(COEF_DEPTH));
   assign res_we = (state_ff == S_LOAD);
   assign rd_en = (state_ff == S_ISSUE);
   assign pred_raw = dbyte[3:0];

   always_comb begin
      case (term_ff)
         4'd0:    coef_k = {1'b0, half_pos};
         4'd1:    coef_k = {1'b1, half_pos};
         default: coef_k = term_ff + 4'd6;
      endcase
      coef_raddr = COEF_AW'({pred_ff, coef_k});
      res_raddr = half_pos + 3'd1 - term_ff[2:0];
   end

   always_comb begin
      case (sel_ff)
         OPB_OLDER: opb = older_ff;
         OPB_NEWER: opb = newer_ff;
         default:   opb = res_rd_ff;
      endcase
      mac_ctl.init = res_we;
      mac_ctl.resid = res_cur;
      mac_ctl.valid = rd_valid_ff;
   end

   always_comb begin
      state_in = state_ff;
      two_bit_in = csr_we ? csr_wdata : two_bit_ff;
      pos_in = pos_ff;
      kk_in = kk_ff;
      byte_in = byte_ff;
      mode_in = mode_ff;
      scale_in = scale_ff;
      pred_in = pred_ff;
      older_in = older_ff;
      newer_in = newer_ff;
      six_in = six_ff;
      term_in = term_ff;
      rd_valid_in = rd_en;
      sel_in = sel_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (op)
                  OP_HIST: begin
                     if (idx == HIST_OLDER) begin
                        older_in = val;
                     end else if (idx == HIST_NEWER) begin
                        newer_in = val;
                     end
                  end
                  OP_HEADER: begin
                     scale_in = dbyte[7:4];
                     if (5'(pred_raw) >= 5'(NUM_PREDICTORS)) begin
                        pred_in = PRED_W'(NUM_PREDICTORS - 1);
                     end else begin
                        pred_in = PRED_W'(pred_raw);
                     end
                     pos_in = 5'd0;
                  end
                  OP_DATA: begin
                     if (!pos_ff[4]) begin
                        byte_in = dbyte;
                        mode_in = two_bit_ff;
                        kk_in = 2'd0;
                        state_in = S_LOAD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LOAD: begin
            term_in = 4'd0;
            state_in = S_ISSUE;
         end
         S_ISSUE: begin
            case (term_ff)
               4'd0:    sel_in = OPB_OLDER;
               4'd1:    sel_in = OPB_NEWER;
               default: sel_in = OPB_RESID;
            endcase
            term_in = term_ff + 4'd1;
            if (term_ff == last_term) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!rd_valid_ff && !mac_busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               if (half_pos == 3'd6) begin
                  six_in = sample_cur;
               end
               if (half_pos == 3'd7) begin
                  older_in = six_ff;
                  newer_in = sample_cur;
               end
               pos_in = pos_ff + 5'd1;
               kk_in = kk_ff + 2'd1;
               state_in = sample_last ? S_IDLE : S_LOAD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_idx_in = rsp_idx_ff;
      rsp_last_in = rsp_last_ff;
      rsp_done_in = rsp_done_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_sample_in = sample_cur;
         rsp_idx_in = pos_ff[3:0];
         rsp_last_in = sample_last;
         rsp_done_in = (pos_ff == LAST_POS);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         two_bit_ff <= 1'b0;
         pos_ff <= 5'd0;
         kk_ff <= 2'd0;
         mode_ff <= 1'b0;
         scale_ff <= 4'd0;
         pred_ff <= '0;
         older_ff <= 16'sd0;
         newer_ff <= 16'sd0;
         six_ff <= 16'sd0;
         term_ff <= 4'd0;
         rd_valid_ff <= 1'b0;
         sel_ff <= OPB_OLDER;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         two_bit_ff <= two_bit_in;
         pos_ff <= pos_in;
         kk_ff <= kk_in;
         mode_ff <= mode_in;
         scale_ff <= scale_in;
         pred_ff <= pred_in;
         older_ff <= older_in;
         newer_ff <= newer_in;
         six_ff <= six_in;
         term_ff <= term_in;
         rd_valid_ff <= rd_valid_in;
         sel_ff <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[idx[COEF_AW-1:0]] <= val;
      end
      if (rd_en) begin
         coef_rd_ff <= coef_mem[coef_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (res_we) begin
         res_mem[half_pos] <= res_cur;
      end
      if (rd_en) begin
         res_rd_ff <= res_mem[res_raddr];
      end
   end

   vfd_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .coef  (coef_rd_ff),
      .opb   (opb),
      .acc   (mac_acc),
      .busy  (mac_busy)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {4'b0, rsp_idx_ff, rsp_sample_ff};
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tuser = rsp_done_ff;

`ifndef NO_ASSERTIONS
   a_term_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ISSUE) |-> (term_ff <= last_term))
      else $error("product index past last term");
   a_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (!rd_valid_ff && !mac_busy))
      else $error("sample taken before accumulation finished");
   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !pos_ff[4])
      else $error("decoding beyond frame end");
   a_frame_end_last: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && (pos_ff == LAST_POS)) |=> (rsp_tlast && rsp_tuser))
      else $error("final frame sample not marked");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && (state_ff == S_DONE)) |=> (state_ff == S_DONE))
      else $error("sample advanced while output stalled");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for vadpcm_frame_decoder: directed and random op streams
// with bursty input and stalling output, checked sample by sample.
// Depends on rtl/vfd_pkg.sv and the decoder RTL; needs no other file.
`timescale 1ns / 1ps

import vfd_pkg::*;

typedef struct packed {
   logic signed [15:0] sample;
   logic [3:0]         pos;
   logic               last;
   logic               done;
} decoded_sample_type;

class sample_scoreboard;
   logic signed [15:0] coef_mem [256];
   logic signed [15:0] resid_mem [8];
   logic signed [15:0] hist_old;
   logic signed [15:0] hist_new;
   logic signed [15:0] sample_six;
   logic [3:0]         scale;
   logic [3:0]         pred;
   logic [4:0]         pos;
   logic               two_bit;
   decoded_sample_type samples_due [$];
   int                 errors;
   int                 samples_checked;
   int                 frames_closed;

   function new();
      foreach (coef_mem[n]) coef_mem[n] = '0;
      foreach (resid_mem[n]) resid_mem[n] = '0;
      hist_old = '0;
      hist_new = '0;
      sample_six = '0;
      scale = '0;
      pred = '0;
      pos = '0;
      two_bit = 1'b0;
      errors = 0;
      samples_checked = 0;
      frames_closed = 0;
   endfunction

   function logic signed [15:0] unpack_resid(logic [7:0] b, int k);
      logic [15:0] placed;
      int          rng;
      int          shamt;
      if (two_bit) begin
         placed = {b[(7 - 2 * k) -: 2], 14'b0};
         rng = 14;
      end else begin
         placed = {b[(7 - 4 * k) -: 4], 12'b0};
         rng = 12;
      end
      shamt = (int'(scale) < rng) ? rng - int'(scale) : 0;
      return $signed(placed) >>> shamt;
   endfunction

   function logic signed [15:0] predict_sample(int i);
      int base;
      int acc;
      int t;
      base = int'(pred) * 16;
      acc = int'(resid_mem[i]) * 2048;
      acc += int'(coef_mem[base + i]) * int'(hist_old);
      acc += int'(coef_mem[base + 8 + i]) * int'(hist_new);
      for (int j = 0; j < i; j++) begin
         acc += int'(coef_mem[base + 8 + j]) * int'(resid_mem[i - 1 - j]);
      end
      t = acc >>> 11;
      if (t > 32767) begin
         t = 32767;
      end else if (t < -32768) begin
         t = -32768;
      end
      return t[15:0];
   endfunction

   function void accept_op(logic [1:0] op, logic [7:0] idx, logic signed [15:0] val,
                           logic [7:0] b);
      int                 per;
      int                 n;
      int                 i;
      decoded_sample_type s;
      case (op)
         OP_COEF: coef_mem[idx] = val;
         OP_HIST: begin
            if (idx == HIST_OLDER) begin
               hist_old = val;
            end else if (idx == HIST_NEWER) begin
               hist_new = val;
            end
         end
         OP_HEADER: begin
            scale = b[7:4];
            pred = b[3:0];
            pos = '0;
         end
         default: begin
            if (pos < 5'd16) begin
               per = two_bit ? 4 : 2;
               n = (per > 16 - int'(pos)) ? 16 - int'(pos) : per;
               for (int k = 0; k < n; k++) begin
                  i = int'(pos[2:0]);
                  resid_mem[i] = unpack_resid(b, k);
                  s.sample = predict_sample(i);
                  if (i == 6) begin
                     sample_six = s.sample;
                  end
                  if (i == 7) begin
                     hist_old = sample_six;
                     hist_new = s.sample;
                  end
                  s.pos = pos[3:0];
                  s.last = (k == n - 1);
                  s.done = (pos == LAST_POS);
                  samples_due.push_back(s);
                  pos++;
               end
            end
         end
      endcase
   endfunction

   function void check_sample(logic [RSP_DATA_W-1:0] d, logic tl, logic tu);
      decoded_sample_type want;
      if (samples_due.size() == 0) begin
         errors++;
         if (errors <= 10) begin
            $display("unexpected sample %0d at position %0d", $signed(d[15:0]), d[19:16]);
         end
         return;
      end
      want = samples_due.pop_front();
      samples_checked++;
      if (want.done) begin
         frames_closed++;
      end
      if (d[15:0] !== want.sample || d[19:16] !== want.pos || tl !== want.last ||
          tu !== want.done) begin
         errors++;
         if (errors <= 10) begin
            $display("sample mismatch: want %0d pos %0d last %b done %b",
                     want.sample, want.pos, want.last, want.done);
            $display("                 got  %0d pos %0d last %b done %b",
                     $signed(d[15:0]), d[19:16], tl, tu);
         end
      end
   endfunction
endclass

module tb_top;
   localparam int ITEM_TARGET   = 210;
   localparam int SETTLE_CYCLES = 64;
   localparam int IDLE_LIMIT    = 1000;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic                  csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;

   sample_scoreboard sb = new();

   int items_sent;
   int burst_left;
   int idle_cycles;
   int rx_style;
   int rx_left;
   int mode_writes;
   bit pred_ready [16];

   vadpcm_frame_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_style = $urandom_range(0, 3);
         rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_style)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 1) == 1);
         2: rsp_tready <= ($urandom_range(0, 7) != 0);
         default: rsp_tready <= ((rx_left % 24) >= 20);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         sb.accept_op(req_tuser, req_tdata[7:0], req_tdata[23:8], req_tdata[31:24]);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_sample(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic send_item(input op_type op, input logic [7:0] idx, input logic [15:0] val,
                            input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {b, val, idx};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.samples_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_mode(input logic m);
      csr_we <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.two_bit = m;
      mode_writes++;
   endtask

   task automatic load_predictor(input logic [3:0] p, input bit wide);
      logic [15:0] c;
      for (int k = 0; k < 16; k++) begin
         if (wide) begin
            c = 16'($urandom);
         end else begin
            c = 16'($signed($urandom_range(0, 8191)) - 4096);
         end
         send_item(OP_COEF, {p, 4'(k)}, c, 8'($urandom));
      end
      pred_ready[p] = 1'b1;
   endtask

   task automatic run_frame();
      logic [3:0] p;
      int         fb;
      int         nbytes;
      if ($urandom_range(0, 4) == 0) begin
         load_predictor(4'($urandom_range(0, 15)), $urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(1, 2)) begin
            send_item(OP_HIST,
                      ($urandom_range(0, 5) == 0) ? 8'($urandom_range(2, 255))
                                                  : 8'($urandom_range(0, 1)),
                      16'($urandom), 8'($urandom));
         end
      end
      if ($urandom_range(0, 7) != 0) begin
         do p = 4'($urandom_range(0, 15)); while (!pred_ready[p]);
         send_item(OP_HEADER, 8'($urandom), 16'($urandom),
                   {4'($urandom_range(0, 15)), p});
      end
      fb = sb.two_bit ? 4 : 8;
      case ($urandom_range(0, 5))
         0: nbytes = $urandom_range(1, fb - 1);
         1: nbytes = fb + $urandom_range(1, 2);
         default: nbytes = fb;
      endcase
      repeat (nbytes) send_item(OP_DATA, 8'($urandom), 16'($urandom), 8'($urandom));
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_COEF;
      rsp_tready = 1'b0;
      items_sent = 0;
      burst_left = 0;
      idle_cycles = 0;
      rx_left = 0;
      mode_writes = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_mode(1'b0);

      // codebooks for the lowest and highest predictor, the lowest with extreme taps
      for (int k = 0; k < 16; k++) begin
         send_item(OP_COEF, 8'(k),
                   (k == 0) ? 16'h8000 : (k == 8) ? 16'h7fff
                            : 16'($signed($urandom_range(0, 4095)) - 2048), 8'($urandom));
      end
      pred_ready[0] = 1'b1;
      for (int k = 0; k < 16; k++) begin
         send_item(OP_COEF, {4'hf, 4'(k)}, 16'($urandom), 8'($urandom));
      end
      pred_ready[15] = 1'b1;

      send_item(OP_DATA, 8'h00, 16'h0000, 8'h7f);
      send_item(OP_HIST, HIST_OLDER, 16'h8000, 8'h00);
      send_item(OP_HIST, HIST_NEWER, 16'h7fff, 8'hff);
      send_item(OP_HIST, 8'hff, 16'h5555, 8'haa);
      send_item(OP_HEADER, 8'hff, 16'hffff, 8'hf0);
      send_item(OP_DATA, 8'h00, 16'h0000, 8'h80);
      send_item(OP_DATA, 8'h00, 16'h0000, 8'h7f);
      send_item(OP_HEADER, 8'h00, 16'h0000, 8'hcf);
      send_item(OP_DATA, 8'h00, 16'h0000, 8'h08);
      send_item(OP_DATA, 8'h00, 16'h0000, 8'hff);
      send_item(OP_HEADER, 8'h00, 16'h0000, 8'h5f);
      send_item(OP_DATA, 8'h00, 16'h0000, 8'h80);
      send_item(OP_DATA, 8'h00, 16'h0000, 8'h7f);
      send_item(OP_DATA, 8'h00, 16'h0000, 8'h08);
      send_item(OP_DATA, 8'h00, 16'h0000, 8'hff);
      send_item(OP_DATA, 8'h00, 16'h0000, 8'h00);
      send_item(OP_DATA, 8'h00, 16'h0000, 8'hf1);
      send_item(OP_DATA, 8'h00, 16'h0000, 8'h88);
      // switch width with two samples left: the byte is cut at the frame end
      settle();
      write_mode(1'b1);
      send_item(OP_DATA, 8'h00, 16'h0000, 8'he4);
      send_item(OP_DATA, 8'h00, 16'h0000, 8'h1b);
      send_item(OP_HEADER, 8'h00, 16'h0000, 8'he0);
      send_item(OP_DATA, 8'h00, 16'h0000, 8'h00);
      send_item(OP_DATA, 8'h00, 16'h0000, 8'hff);
      send_item(OP_DATA, 8'h00, 16'h0000, 8'h80);
      send_item(OP_DATA, 8'h00, 16'h0000, 8'h7f);
      send_item(OP_DATA, 8'h00, 16'h0000, 8'h55);

      while (items_sent < ITEM_TARGET) begin
         settle();
         write_mode(1'($urandom_range(0, 1)));
         repeat ($urandom_range(1, 4)) run_frame();
      end
      settle();

      if (sb.samples_due.size() != 0) begin
         sb.errors += sb.samples_due.size();
         $display("%0d expected samples never arrived", sb.samples_due.size());
      end
      $display("covered %0d input transfers and %0d samples (%0d complete frames)",
               items_sent, sb.samples_checked, sb.frames_closed);
      $display("across %0d width settings, with cut bytes, stale data and bad history selects",
               mode_writes);
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

// ===== vadpcm_frame_decoder.f =====
rtl/vfd_pkg.sv
rtl/vfd_mac.sv
rtl/vadpcm_frame_decoder.sv
bench/tb_top.sv
